FILE: rtl/core/plla_pkg.sv
// ----------------------------------------------------------------------------
// plla_pkg: shared types and constants
// Field widths, sequencer states and root unit sizes for the polyline core.
// ----------------------------------------------------------------------------
`default_nettype none

package plla_pkg;

  localparam int unsigned COORD_W = 32;  // vertex coordinate field
  localparam int unsigned LEN_W   = 48;  // unsigned Q32.16 length sum
  localparam int unsigned AREA_W  = 64;  // signed Q47.16 area sum
  localparam int unsigned PROD_W  = 2 * COORD_W;
  localparam int unsigned RAD_W   = PROD_W + 2;   // sum of squares, pair aligned
  localparam int unsigned ROOT_W  = RAD_W / 2;    // one root bit per pair
  localparam int unsigned REM_W   = ROOT_W + 3;
  localparam int unsigned CNT_W   = $clog2(ROOT_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_A,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_COMMIT
  } plla_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/polyline_length_and_area_core.sv
// Path: a polyline opener goes from ST_DIFF to ST_COMMIT; any other vertex goes through the
// multiply states, ST_ROOT_GO and ST_ROOT_WAIT (33 root iterations), then ST_COMMIT.
// A vertex is taken only when the last one is done; the bit-pair root loop is the longest step;
// in_stall_o is high while a vertex is in work, low again once its beat is posted.
// Reset (rst_ni, async, active low): sums, flag and previous vertex clear,
// the next vertex is treated as the first of a polyline.
// ----------------------------------------------------------------------------
// polyline_length_and_area_core: running polyline length and shoelace area
// One shared 33x33 multiplier and an iterative square root under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_length_and_area_core #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // vertex channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [plla_pkg::COORD_W-1:0] x_coord_i,
  input  wire logic signed [plla_pkg::COORD_W-1:0] y_coord_i,
  input  wire logic                              first_point_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [plla_pkg::LEN_W-1:0]             length_sum_o,
  output logic signed [plla_pkg::AREA_W-1:0]     area_sum_o,
  output logic                                   saturated_o
);
  import plla_pkg::*;

  // coordinates are taken as COORD_BITS-bit two's complement, capped at the field
  localparam int unsigned CW         = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int unsigned EXT_SHIFT  = COORD_W - CW;
  localparam int unsigned AREA_SHIFT = FRAC_BITS + 1;
  localparam logic [PROD_W:0] ROUND_MASK = (PROD_W+1)'((65'd1 << AREA_SHIFT) - 65'd1);
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

  plla_state_e state_q, state_d;

  // input capture, sign extended to the field width
  logic [COORD_W-1:0] x_shl, y_shl;
  logic [COORD_W-1:0] x_ext, y_ext;
  logic [COORD_W-1:0] x_q, y_q;
  logic               first_q;

  // previous vertex and running sums
  logic [COORD_W-1:0] px_q, py_q;
  logic               have_prev_q;
  logic [LEN_W-1:0]   len_acc_q;
  logic [AREA_W-1:0]  area_acc_q;
  logic               sat_q;
  logic               out_valid_q;

  // datapath
  logic [COORD_W:0]   dx, dy, sx;
  logic [COORD_W-1:0] ax_q, ay_q;
  logic [COORD_W:0]   asx_q;
  logic               area_neg_q;
  logic [COORD_W:0]   op_a, op_b;
  logic [PROD_W-1:0]  prod_q, qx_q;
  logic [RAD_W-1:0]   rad_q;
  logic [PROD_W:0]    m_rnd;
  logic [AREA_W-1:0]  tmag_q;
  logic               tneg_q;
  logic [AREA_W-1:0]  term_q;

  // iterative square root unit
  logic               root_start;
  logic               root_done;
  logic [ROOT_W-1:0]  root;

  // commit-time sums
  logic [LEN_W:0]     len_sum;
  logic [AREA_W-1:0]  area_sum;
  logic               area_ovf;
  logic               out_free;
  logic               restart;

  assign x_shl = x_coord_i << EXT_SHIFT;
  assign y_shl = y_coord_i << EXT_SHIFT;
  assign x_ext = COORD_W'($signed(x_shl) >>> EXT_SHIFT);
  assign y_ext = COORD_W'($signed(y_shl) >>> EXT_SHIFT);

  assign dx = {x_q[COORD_W-1], x_q} - {px_q[COORD_W-1], px_q};
  assign dy = {y_q[COORD_W-1], y_q} - {py_q[COORD_W-1], py_q};
  assign sx = {x_q[COORD_W-1], x_q} + {px_q[COORD_W-1], px_q};

  // floor toward minus infinity: a negative term rounds its magnitude up
  assign m_rnd = {1'b0, prod_q} + ROUND_MASK;

  assign out_free = !out_valid_q || !out_stall_i;
  assign restart  = first_q || !have_prev_q;

  // saturating accumulate, only looked at in ST_COMMIT
  assign len_sum  = {1'b0, len_acc_q} + (LEN_W+1)'(root);
  assign area_sum = area_acc_q + term_q;
  assign area_ovf = (area_acc_q[AREA_W-1] == term_q[AREA_W-1]) &&
                    (area_sum[AREA_W-1] != area_acc_q[AREA_W-1]);

  plla_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (rad_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_DIFF;
      ST_DIFF:      state_d = restart ? ST_COMMIT : ST_MUL_X;
      ST_MUL_X:     state_d = ST_MUL_Y;
      ST_MUL_Y:     state_d = ST_MUL_A;
      ST_MUL_A:     state_d = ST_ROOT_GO;
      ST_ROOT_GO:   state_d = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (root_done) state_d = ST_COMMIT;
      ST_COMMIT:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs and multiplier operand select
  always_comb begin
    in_stall_o = 1'b1;
    root_start = 1'b0;
    op_a       = {1'b0, ax_q};
    op_b       = {1'b0, ax_q};
    unique case (state_q)
      ST_IDLE:    in_stall_o = 1'b0;
      ST_MUL_Y: begin
        op_a = {1'b0, ay_q};
        op_b = {1'b0, ay_q};
      end
      ST_MUL_A: begin
        op_a = {1'b0, ay_q};
        op_b = asx_q;
      end
      ST_ROOT_GO: root_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      have_prev_q <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      len_acc_q   <= '0;
      area_acc_q  <= '0;
      sat_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_COMMIT && out_free) begin
        out_valid_q <= 1'b1;
        have_prev_q <= 1'b1;
        px_q        <= x_q;
        py_q        <= y_q;
        if (restart) begin
          len_acc_q  <= '0;
          area_acc_q <= '0;
          sat_q      <= 1'b0;
        end else begin
          // length sticks at full scale
          len_acc_q <= len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
          // area clamps toward the side it overflowed on
          if (area_ovf) begin
            area_acc_q <= area_acc_q[AREA_W-1] ? AREA_MIN : AREA_MAX;
          end else begin
            area_acc_q <= area_sum;
          end
          if (len_sum[LEN_W] || area_ovf) sat_q <= 1'b1;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      x_q     <= x_ext;
      y_q     <= y_ext;
      first_q <= first_point_i;
    end
    if (state_q == ST_DIFF) begin
      // |dx|, |dy| < 2^32; |x + x_prev| reaches 2^32 when both sit at the negative limit
      ax_q       <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ay_q       <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      asx_q      <= sx[COORD_W] ? -sx : sx;
      area_neg_q <= dy[COORD_W] ^ sx[COORD_W];
    end
    if (state_q == ST_MUL_X || state_q == ST_MUL_Y || state_q == ST_MUL_A) begin
      prod_q <= {{(COORD_W-1){1'b0}}, op_a} * {{(COORD_W-1){1'b0}}, op_b};
    end
    if (state_q == ST_MUL_Y) qx_q <= prod_q;
    if (state_q == ST_MUL_A) rad_q <= {1'b0, {1'b0, qx_q} + {1'b0, prod_q}};
    if (state_q == ST_ROOT_GO) begin
      tneg_q <= area_neg_q && (prod_q != '0);
      tmag_q <= area_neg_q ? AREA_W'(m_rnd >> AREA_SHIFT)
                           : AREA_W'(prod_q >> AREA_SHIFT);
    end
    if (state_q == ST_ROOT_WAIT) begin
      term_q <= tneg_q ? (~tmag_q + AREA_W'(1)) : tmag_q;
    end
  end

  // sums only change at commit, when the result register is free
  assign out_valid_o  = out_valid_q;
  assign length_sum_o = len_acc_q;
  assign area_sum_o   = area_acc_q;
  assign saturated_o  = sat_q;

endmodule

`default_nettype wire

FILE: rtl/core/plla_isqrt.sv
// ----------------------------------------------------------------------------
// plla_isqrt: iterative integer square root
// Restoring digit-by-digit root, one radicand bit pair per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plla_isqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [plla_pkg::RAD_W-1:0] rad_i,
  output logic                            done_o,
  output logic [plla_pkg::ROOT_W-1:0]     root_o
);
  import plla_pkg::*;

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // shift in the next pair, try subtracting 4*root+1
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire
